// ===== src/bda_pkg.sv =====
package bda_pkg;

    localparam int unsigned DEBOUNCE_TICKS_DEF = 20;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_MODE          = 3'd0,
        CFG_WRAP_LOW      = 3'd1,
        CFG_WRAP_HIGH     = 3'd2,
        CFG_REPEAT_PERIOD = 3'd3,
        CFG_ACCEL1_AFTER  = 3'd4,
        CFG_ACCEL1_PERIOD = 3'd5,
        CFG_ACCEL2_AFTER  = 3'd6,
        CFG_ACCEL2_PERIOD = 3'd7
    } cfg_idx_t;

    // low two mode bits select the repeat speed, bit 2 selects switch behavior
    localparam logic [1:0] SPEED_NONE   = 2'd0;
    localparam logic [1:0] SPEED_REPEAT = 2'd1;
    localparam logic [1:0] SPEED_ACCEL1 = 2'd2;
    localparam logic [1:0] SPEED_ACCEL2 = 2'd3;
    localparam int unsigned MODE_SWITCH_BIT = 2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  wrap_low;
        logic [7:0]  wrap_high;
        logic [15:0] repeat_period;
        logic [15:0] accel1_after;
        logic [15:0] accel1_period;
        logic [15:0] accel2_after;
        logic [15:0] accel2_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:          3'd0,
        wrap_low:      8'd0,
        wrap_high:     8'd1,
        repeat_period: 16'd50,
        accel1_after:  16'd5,
        accel1_period: 16'd20,
        accel2_after:  16'd10,
        accel2_period: 16'd5
    };

    typedef struct packed {
        logic [7:0]  debounce_count;
        logic [15:0] hold_ticks;
        logic [15:0] repeat_count;
        logic [7:0]  current_state;
        logic        changed_flag;
    } btn_state_t;

endpackage

// ===== src/bda_step.sv =====
module bda_step #(
    parameter int unsigned DEBOUNCE_TICKS = bda_pkg::DEBOUNCE_TICKS_DEF
) (
    input  bda_pkg::func_t      func,
    input  logic                pin_level,
    input  logic [7:0]          write_value,
    input  bda_pkg::cfg_t       cfg,
    input  bda_pkg::btn_state_t cur,
    output bda_pkg::btn_state_t nxt,
    output logic [7:0]          state_value,
    output logic                changed
);
    import bda_pkg::*;

    localparam logic [7:0] DB_LAST = 8'(DEBOUNCE_TICKS);

    logic [1:0]  speed;
    logic        is_switch;
    logic [15:0] period_sel;
    logic [15:0] period;
    logic [15:0] hold_eff;
    logic        fire;
    logic [8:0]  step_sum;
    logic [7:0]  step_val;
    logic [7:0]  fired_state;
    logic [7:0]  high_state;
    logic [15:0] high_repeat;
    logic [15:0] high_hold;

    assign speed     = cfg.mode[1:0];
    assign is_switch = cfg.mode[MODE_SWITCH_BIT];

    // phase selection for the repeat period
    always_comb
    begin
        priority if (speed == SPEED_ACCEL2 && cur.repeat_count > cfg.accel2_after)
        begin
            period_sel = cfg.accel2_period;
        end
        else if (speed >= SPEED_ACCEL1 && cur.repeat_count > cfg.accel1_after)
        begin
            period_sel = cfg.accel1_period;
        end
        else
        begin
            period_sel = cfg.repeat_period;
        end
    end

    // a zero period behaves as one
    assign period   = (period_sel == 16'd0) ? 16'd1 : period_sel;
    assign hold_eff = (speed != SPEED_NONE && cur.hold_ticks == period) ? 16'd0
                                                                       : cur.hold_ticks;
    assign fire     = (hold_eff == 16'd0);

    // step in 9 bits so 255 does not wrap to zero
    assign step_sum    = {1'b0, cur.current_state} + 9'd1;
    assign step_val    = (step_sum > {1'b0, cfg.wrap_high}) ? cfg.wrap_low : step_sum[7:0];
    assign fired_state = fire ? (is_switch ? step_val : 8'd1) : cur.current_state;
    assign high_state  = (is_switch && fired_state > cfg.wrap_high) ? cfg.wrap_low
                                                                    : fired_state;
    assign high_repeat = (fire && speed >= SPEED_ACCEL1 && cur.repeat_count != COUNT_MAX)
                         ? cur.repeat_count + 16'd1 : cur.repeat_count;
    assign high_hold   = (hold_eff != COUNT_MAX) ? hold_eff + 16'd1 : hold_eff;

    always_comb
    begin
        nxt         = cur;
        state_value = cur.current_state;
        changed     = cur.changed_flag;
        unique case (func)
            FUNC_TICK:
            begin
                priority if (cur.debounce_count == 8'd0 && pin_level)
                begin
                    nxt.debounce_count = cur.debounce_count + 8'd1;
                end
                else if (cur.debounce_count != 8'd0 && cur.debounce_count < DB_LAST)
                begin
                    nxt.debounce_count = cur.debounce_count + 8'd1;
                end
                else if (pin_level)
                begin
                    nxt.hold_ticks    = high_hold;
                    nxt.repeat_count  = high_repeat;
                    nxt.current_state = high_state;
                    nxt.changed_flag  = fire | cur.changed_flag;
                end
                else
                begin
                    nxt.debounce_count = 8'd0;
                    nxt.hold_ticks     = 16'd0;
                    nxt.repeat_count   = 16'd0;
                end
                state_value = nxt.current_state;
                changed     = nxt.changed_flag;
            end
            FUNC_READ:
            begin
                // normal modes consume the press, switch modes keep the value
                if (!is_switch)
                begin
                    nxt.current_state = 8'd0;
                end
                nxt.changed_flag = 1'b0;
            end
            FUNC_WRITE:
            begin
                nxt.current_state = write_value;
                nxt.changed_flag  = 1'b1;
                state_value       = write_value;
                changed           = 1'b1;
            end
            FUNC_CLEAR:
            begin
                nxt         = '0;
                state_value = 8'd0;
                changed     = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/button_debounce_autorepeat_core.sv =====
// Button debouncer with auto-repeat, two-step acceleration and a cycling switch value.
// One word is accepted every clock cycle while in_stall is low; its result passes through
// one input register, combinational logic for the state update, and one result register,
// and the combinational state update is what sets the one-word-per-cycle rate.
// A word taken in while a result is stalled waits in the input register. Configuration
// writes take effect on the next clock edge and are expected only while no word is in flight.
module button_debounce_autorepeat_core #(
    parameter int unsigned DEBOUNCE_TICKS = bda_pkg::DEBOUNCE_TICKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bda_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic                              pin_level,
    input  logic [7:0]                        write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        state_value,
    output logic                              changed
);
    import bda_pkg::*;

    cfg_t       cfg_reg;
    btn_state_t st_reg;
    btn_state_t st_next;

    logic       s1_valid_reg;
    func_t      s1_func_reg;
    logic       s1_pin_reg;
    logic [7:0] s1_wval_reg;

    logic       out_valid_reg;
    logic [7:0] out_state_reg;
    logic       out_changed_reg;
    logic [7:0] out_state_next;
    logic       out_changed_next;

    logic       out_free;
    logic       advance;
    logic       in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:          cfg_reg.mode          <= cfg_data[2:0];
                CFG_WRAP_LOW:      cfg_reg.wrap_low      <= cfg_data[7:0];
                CFG_WRAP_HIGH:     cfg_reg.wrap_high     <= cfg_data[7:0];
                CFG_REPEAT_PERIOD: cfg_reg.repeat_period <= cfg_data;
                CFG_ACCEL1_AFTER:  cfg_reg.accel1_after  <= cfg_data;
                CFG_ACCEL1_PERIOD: cfg_reg.accel1_period <= cfg_data;
                CFG_ACCEL2_AFTER:  cfg_reg.accel2_after  <= cfg_data;
                CFG_ACCEL2_PERIOD: cfg_reg.accel2_period <= cfg_data;
            endcase
        end
    end

    bda_step #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_step (
        .func        (s1_func_reg),
        .pin_level   (s1_pin_reg),
        .write_value (s1_wval_reg),
        .cfg         (cfg_reg),
        .cur         (st_reg),
        .nxt         (st_next),
        .state_value (out_state_next),
        .changed     (out_changed_next)
    );

    // control and button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_func_reg     <= FUNC_TICK;
            s1_pin_reg      <= 1'b0;
            s1_wval_reg     <= 8'd0;
            out_state_reg   <= 8'd0;
            out_changed_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_func_reg <= func_t'(func);
                s1_pin_reg  <= pin_level;
                s1_wval_reg <= write_value;
            end
            if (advance)
            begin
                out_state_reg   <= out_state_next;
                out_changed_reg <= out_changed_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign state_value = out_state_reg;
    assign changed     = out_changed_reg;

    // debounce counter stops at its limit
    a_db_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.debounce_count <= 8'(DEBOUNCE_TICKS))
        else $error("debounce count beyond limit");

    // button state moves only when a word is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("state changed without a word");

    // a clear word leaves every counter and flag at zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_func_reg == FUNC_CLEAR |=> st_reg == '0 && !out_changed_reg)
        else $error("clear word did not clear state");

    // an accepted word is held in the input register
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted word lost");

    // every processed word yields a result on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word has no result");

endmodule
